// ===== rtl/tcprr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcprr_pkg
// Shared types and constants of the TCP receive reassembly block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcprr_pkg;

  localparam int DefReorderDepth = 8;
  localparam int DefHandleBits   = 8;
  localparam int QueueDepth      = 2;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_LOCAL_PORT  = 2'd0;
  localparam logic [1:0] CFG_REMOTE_PORT = 2'd1;
  localparam logic [1:0] CFG_REMOTE_ADDR = 2'd2;
  localparam logic [1:0] CFG_RECV_WINDOW = 2'd3;

  localparam logic [15:0] RST_LOCAL_PORT  = 16'd21550;
  localparam logic [15:0] RST_RECV_WINDOW = 16'd8192;
  localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    DROP_NONE      = 3'd0,
    DROP_SHORT_HDR = 3'd1,
    DROP_SHORT_PKT = 3'd2,
    DROP_NO_MATCH  = 3'd3,
    DROP_BAD_CSUM  = 3'd4,
    DROP_FULL      = 3'd5
  } drop_t;

  // Classified segment handed from the front to the back.
  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] seq;
    logic        syn;
    logic        ack;
    logic        fin;
    logic [15:0] length;
    drop_t       reason;
  } seg_item_t;

  // One parked segment of the reorder table.
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] length;
    logic        fin;
    logic [7:0]  handle;
  } slot_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  handle;
    logic [31:0] ack_number;
    logic [15:0] window;
    logic        peer_closed;
    drop_t       reason;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EVAL,
    B_STALE_DISC,
    B_SCAN,
    B_DECIDE,
    B_FINISH
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/tcprr_front.sv =====
// ----------------------------------------------------------------------------
// tcprr_front
// Holds the configuration registers and classifies each arriving segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprr_front import tcprr_pkg::*; #(
  parameter int HANDLE_BITS = DefHandleBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [7:0]  in_segment_handle,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_flag_syn,
  input  wire logic        in_flag_ack,
  input  wire logic        in_flag_fin,
  input  wire logic [3:0]  in_header_words,
  input  wire logic [15:0] in_total_length,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [31:0] in_source_addr,
  input  wire logic        in_checksum_bad,
  output logic [15:0]      recv_window,
  output seg_item_t        item
);

  localparam logic [16:0] HandleMaskWide = (17'd1 << HANDLE_BITS) - 17'd1;

  logic [15:0] local_port_r;
  logic [15:0] remote_port_r;
  logic [31:0] remote_addr_r;
  logic [15:0] recv_window_r;
  logic [15:0] hdr_bytes;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_port_r  <= RST_LOCAL_PORT;
      remote_port_r <= '0;
      remote_addr_r <= '0;
      recv_window_r <= RST_RECV_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_PORT:  local_port_r  <= cfg_data[15:0];
        CFG_REMOTE_PORT: remote_port_r <= cfg_data[15:0];
        CFG_REMOTE_ADDR: remote_addr_r <= cfg_data;
        CFG_RECV_WINDOW: recv_window_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign recv_window = recv_window_r;
  assign hdr_bytes   = {10'd0, in_header_words, 2'b00};

  // Classify the segment: checks in priority order.
  always_comb begin
    item.handle = in_segment_handle & HandleMaskWide[7:0];
    item.seq    = in_seq_number;
    item.syn    = in_flag_syn;
    item.ack    = in_flag_ack;
    item.fin    = in_flag_fin;
    item.length = in_total_length - hdr_bytes;
    if (in_header_words < MIN_HDR_WORDS) begin
      item.reason = DROP_SHORT_HDR;
    end else if (in_total_length < hdr_bytes) begin
      item.reason = DROP_SHORT_PKT;
    end else if (in_dst_port != local_port_r || in_src_port != remote_port_r ||
                 in_source_addr != remote_addr_r) begin
      item.reason = DROP_NO_MATCH;
    end else if (in_checksum_bad) begin
      item.reason = DROP_BAD_CSUM;
    end else begin
      item.reason = DROP_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcprr_queue.sv =====
// ----------------------------------------------------------------------------
// tcprr_queue
// Short queue of classified segments between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprr_queue import tcprr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  seg_item_t push_item,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output seg_item_t head
);

  localparam int PW = $clog2(QueueDepth);

  seg_item_t     entry_r [QueueDepth];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  assign full      = (count_r == (PW+1)'(QueueDepth));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/tcprr_back.sv =====
// ----------------------------------------------------------------------------
// tcprr_back
// Carries out each segment: establishment, parking, ordered release, acks.
// ----------------------------------------------------------------------------
`default_nettype none

module tcprr_back import tcprr_pkg::*; #(
  parameter int REORDER_DEPTH = DefReorderDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  seg_item_t        q_item,
  output logic             q_pop,
  input  wire logic [15:0] recv_window,
  output logic             res_valid,
  output result_t          res
);

  localparam int IW = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
  localparam int CW = $clog2(REORDER_DEPTH + 1);
  localparam logic [CW-1:0] ScanEnd = CW'(REORDER_DEPTH);

  back_state_t state_r, state_nxt;
  seg_item_t   cur_r, cur_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic        est_r, est_nxt;
  logic        closed_r, closed_nxt;
  logic [REORDER_DEPTH-1:0] valid_r, valid_nxt;
  logic        phase_r, phase_nxt;

  // Scan pipeline.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rd_v_r;
  logic [IW-1:0] rd_idx_r;
  slot_t         rd_r;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  slot_t         best_r, best_nxt;

  // Result staging: one pending result so the final one can carry last.
  logic    pend_v_r, pend_v_nxt;
  result_t pend_r, pend_nxt;
  logic    out_v_r, out_v_nxt;
  result_t out_r, out_nxt;

  slot_t   mem [REORDER_DEPTH];
  logic    wr_en;
  logic [IW-1:0] wr_idx;
  slot_t   wr_slot;

  logic    have_free;
  logic [IW-1:0] free_idx;
  logic    prod;
  result_t prod_res;
  logic [31:0] exp_est;

  // Lowest free slot.
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = REORDER_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_idx  = IW'(i);
      end
    end
  end

  // Next state and actions.
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    exp_nxt      = exp_r;
    est_nxt      = est_r;
    closed_nxt   = closed_r;
    valid_nxt    = valid_r;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    q_pop        = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = free_idx;
    wr_slot      = '{seq: cur_r.seq, length: cur_r.length, fin: cur_r.fin,
                     handle: cur_r.handle};
    prod         = 1'b0;
    prod_res     = '{kind: KIND_DISCARD, handle: cur_r.handle, ack_number: '0,
                     window: '0, peer_closed: closed_r, reason: DROP_NONE,
                     last: 1'b0};
    exp_est      = (cur_r.syn && cur_r.ack && !est_r) ? cur_r.seq + 32'd1 : exp_r;

    // Compare stage of the scan.
    if (rd_v_r && valid_r[rd_idx_r] && (!found_r || rd_r.seq < best_r.seq)) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_nxt     = rd_r;
    end

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        prod = 1'b1;
        if (cur_r.reason != DROP_NONE) begin
          prod_res.reason = cur_r.reason;
          state_nxt       = B_FINISH;
        end else begin
          exp_nxt = exp_est;
          if (cur_r.syn && cur_r.ack) est_nxt = 1'b1;
          if (cur_r.seq < exp_est) begin
            prod_res.kind       = KIND_ACK;
            prod_res.handle     = '0;
            prod_res.ack_number = exp_est;
            prod_res.window     = recv_window;
            state_nxt           = B_STALE_DISC;
          end else if (!have_free) begin
            prod_res.reason = DROP_FULL;
            state_nxt       = B_FINISH;
          end else begin
            prod               = 1'b0;
            wr_en              = 1'b1;
            valid_nxt[free_idx] = 1'b1;
            phase_nxt          = 1'b0;
            cnt_nxt            = '0;
            found_nxt          = 1'b0;
            state_nxt          = B_SCAN;
          end
        end
      end
      B_STALE_DISC: begin
        prod      = 1'b1;
        state_nxt = B_FINISH;
      end
      B_SCAN: begin
        if (cnt_r == ScanEnd) state_nxt = B_DECIDE;
        else                  cnt_nxt   = cnt_r + 1'b1;
      end
      B_DECIDE: begin
        cnt_nxt   = '0;
        found_nxt = 1'b0;
        if (found_r && best_r.seq < exp_r && !phase_r) begin
          // Parked segment that fell behind the expected sequence.
          valid_nxt[best_idx_r] = 1'b0;
          prod            = 1'b1;
          prod_res.handle = best_r.handle;
          state_nxt       = B_SCAN;
        end else if (found_r && best_r.seq == exp_r) begin
          // In-order release.
          valid_nxt[best_idx_r] = 1'b0;
          phase_nxt  = 1'b1;
          exp_nxt    = exp_r + {16'd0, best_r.length} + {31'd0, best_r.fin};
          closed_nxt = closed_r | best_r.fin;
          prod       = 1'b1;
          prod_res.handle      = best_r.handle;
          prod_res.peer_closed = closed_r | best_r.fin;
          prod_res.kind = (best_r.length != '0) ? KIND_DELIVER : KIND_DISCARD;
          state_nxt  = B_SCAN;
        end else if (phase_r) begin
          prod                = 1'b1;
          prod_res.kind       = KIND_ACK;
          prod_res.handle     = '0;
          prod_res.ack_number = exp_r;
          prod_res.window     = recv_window;
          state_nxt           = B_FINISH;
        end else begin
          state_nxt = B_FINISH;
        end
      end
      B_FINISH: begin
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase

    // Result staging.
    out_v_nxt  = 1'b0;
    out_nxt    = pend_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (prod) begin
      out_v_nxt  = pend_v_r;
      pend_v_nxt = 1'b1;
      pend_nxt   = prod_res;
    end else if (state_r == B_FINISH) begin
      out_v_nxt    = pend_v_r;
      out_nxt.last = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      exp_r    <= '0;
      est_r    <= 1'b0;
      closed_r <= 1'b0;
      valid_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      rd_v_r   <= 1'b0;
      found_r  <= 1'b0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      exp_r    <= exp_nxt;
      est_r    <= est_nxt;
      closed_r <= closed_nxt;
      valid_r  <= valid_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      rd_v_r   <= (state_r == B_SCAN) && (cnt_r != ScanEnd);
      found_r  <= found_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    rd_idx_r   <= cnt_r[IW-1:0];
  end

  // Reorder table memory, one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_slot;
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

  a_ack_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == KIND_ACK) |-> (out_r.handle == '0))
    else $error("acknowledgement carries a handle");
  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SCAN) |=> (state_r == B_SCAN || state_r == B_DECIDE))
    else $error("scan left early");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.last) |-> (state_r == B_IDLE && !pend_v_r))
    else $error("last result while work remains");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == B_EVAL))
    else $error("popped item not evaluated");

endmodule

`default_nettype wire

// ===== rtl/tcp_receive_reassembly_top.sv =====
// ----------------------------------------------------------------------------
// tcp_receive_reassembly_top
// Receive side of one TCP connection: checks, reorder table, in-order
// release and acknowledgement generation.
//
//   channel  handshake            fields
//   input    start & !busy        in_segment_handle .. in_checksum_bad
//   result   out_strobe (1 cycle) out_kind .. out_last
//   config   cfg_we               cfg_index, cfg_data
//
// A rejected segment passes B_EVAL and B_FINISH in the back part, and a stale
// one B_EVAL, B_STALE_DISC and B_FINISH. A parked segment passes B_SCAN and
// B_DECIDE once per table scan, one scan per released or discarded slot plus
// one; the scan reads one table entry a cycle.
// Reset is synchronous; the table needs no clearing pass (valid flops).
// busy rises only when the two-entry queue is full; results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_receive_reassembly_top import tcprr_pkg::*; #(
  parameter int REORDER_DEPTH = DefReorderDepth,
  parameter int HANDLE_BITS   = DefHandleBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_segment_handle,
  input  wire logic [31:0] in_seq_number,
  input  wire logic        in_flag_syn,
  input  wire logic        in_flag_ack,
  input  wire logic        in_flag_fin,
  input  wire logic [3:0]  in_header_words,
  input  wire logic [15:0] in_total_length,
  input  wire logic [15:0] in_src_port,
  input  wire logic [15:0] in_dst_port,
  input  wire logic [31:0] in_source_addr,
  input  wire logic        in_checksum_bad,
  output logic             out_strobe,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_handle,
  output logic [31:0]      out_ack_number,
  output logic [15:0]      out_window,
  output logic             out_peer_closed,
  output logic [2:0]       out_drop_reason,
  output logic             out_last
);

  seg_item_t   f_item, q_head;
  logic [15:0] recv_window;
  logic        q_full, q_not_empty, q_pop;
  result_t     res;

  tcprr_front #(.HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_segment_handle, .in_seq_number, .in_flag_syn, .in_flag_ack,
    .in_flag_fin, .in_header_words, .in_total_length, .in_src_port,
    .in_dst_port, .in_source_addr, .in_checksum_bad,
    .recv_window, .item(f_item)
  );

  tcprr_queue u_queue (
    .clk, .rst_n, .push(start && !q_full), .push_item(f_item), .pop(q_pop),
    .full(q_full), .not_empty(q_not_empty), .head(q_head)
  );

  tcprr_back #(.REORDER_DEPTH(REORDER_DEPTH)) u_back (
    .clk, .rst_n, .q_valid(q_not_empty), .q_item(q_head), .q_pop,
    .recv_window, .res_valid(out_strobe), .res
  );

  // Result unpacking.
  assign busy            = q_full;
  assign out_kind        = res.kind;
  assign out_handle      = res.handle;
  assign out_ack_number  = res.ack_number;
  assign out_window      = res.window;
  assign out_peer_closed = res.peer_closed;
  assign out_drop_reason = res.reason;
  assign out_last        = res.last;

endmodule

`default_nettype wire
